>>> rtl/gbp_pkg.sv
// Shared constants and types for the grid block partition block.
// No dependencies; compiled first.
package gbp_pkg;

   localparam int POINT_BITS_DEF = 16;
   localparam int PROC_BITS_DEF  = 12;
   localparam int LAYER_BITS     = 8;
   localparam int CSR_INDEX_BITS = 3;
   localparam int STATUS_BITS    = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TOTAL_X  = 3'd0,
      CSR_TOTAL_Z  = 3'd1,
      CSR_PROCS_X  = 3'd2,
      CSR_PROCS_Z  = 3'd3,
      CSR_LAYER_XL = 3'd4,
      CSR_LAYER_XH = 3'd5,
      CSR_LAYER_ZL = 3'd6,
      CSR_LAYER_ZH = 3'd7
   } csr_index_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_X_SMALL = 2'd1,
      STATUS_Z_SMALL = 2'd2,
      STATUS_RANGE   = 2'd3
   } status_type;

   typedef struct packed {
      logic s1;
      logic s2;
   } advance_type;

endpackage

>>> rtl/gbp_if.sv
// Request and response channel interfaces for the grid block partition block.
// Depends on gbp_pkg for default widths.
interface gbp_req_if #(
   parameter int PROC_BITS = gbp_pkg::PROC_BITS_DEF
) ();
   logic                 valid;
   logic                 ready;
   logic [PROC_BITS-1:0] worker_x;
   logic [PROC_BITS-1:0] worker_z;

   modport source (output valid, output worker_x, output worker_z, input ready);
   modport sink   (input valid, input worker_x, input worker_z, output ready);
endinterface

interface gbp_rsp_if #(
   parameter int POINT_BITS = gbp_pkg::POINT_BITS_DEF
) ();
   logic                         valid;
   logic                         ready;
   logic [POINT_BITS:0]          start_x;
   logic [POINT_BITS:0]          start_z;
   logic [POINT_BITS:0]          count_x;
   logic [POINT_BITS:0]          count_z;
   logic [gbp_pkg::STATUS_BITS-1:0] status;

   modport source (output valid, output start_x, output start_z, output count_x,
                   output count_z, output status, input ready);
   modport sink   (input valid, input start_x, input start_z, input count_x,
                   input count_z, input status, output ready);
endinterface

>>> rtl/gbp_div.sv
// Shift-subtract divider, one quotient bit per cycle, for the per-axis
// average block and remainder. Depends on no package items.
module gbp_div #(
   parameter int DVD_W = 17,
   parameter int DVS_W = 13
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic [DVD_W-1:0] quotient,
   output logic [DVS_W-1:0] remainder,
   output logic             busy
);

   localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DVD_W - 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DVS_W-1:0] part_ff, part_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;
   logic             ge;
   logic [DVS_W-1:0] part_step;
   logic [DVD_W-1:0] dvd_step;

   always_comb begin
      trial     = {part_ff, dvd_ff[DVD_W-1]};
      ge        = trial >= {1'b0, dvs_ff};
      diff      = trial - {1'b0, dvs_ff};
      part_step = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      dvd_step  = {dvd_ff[DVD_W-2:0], ge};

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      part_in = part_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         part_in = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         dvd_in  = dvd_step;
         part_in = part_step;
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            quo_in  = dvd_step;
            rem_in  = part_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         quo_ff  <= DVD_W'(1);
         rem_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         quo_ff  <= quo_in;
         rem_ff  <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff  <= dvd_in;
      part_ff <= part_in;
      dvs_ff  <= dvs_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign busy      = busy_ff;

endmodule

>>> rtl/gbp_axis.sv
// Two pipeline stages of the per-axis split: multiply and checks, then
// start and count. Depends on gbp_pkg for the stage advance struct.
module gbp_axis #(
   parameter int POINT_BITS = gbp_pkg::POINT_BITS_DEF,
   parameter int PROC_BITS  = gbp_pkg::PROC_BITS_DEF,
   parameter int AVG_W      = POINT_BITS + 1
) (
   input  logic                          clock,
   input  gbp_pkg::advance_type          adv,
   input  logic [PROC_BITS-1:0]          idx,
   input  logic [PROC_BITS:0]            procs,
   input  logic [AVG_W-1:0]              avg,
   input  logic [PROC_BITS:0]            rem,
   input  logic [gbp_pkg::LAYER_BITS-1:0] lo,
   input  logic [gbp_pkg::LAYER_BITS-1:0] hi,
   output logic [POINT_BITS:0]           start,
   output logic [POINT_BITS:0]           count,
   output logic                          oob,
   output logic                          undersize
);

   localparam int OUT_W = POINT_BITS + 1;

   logic             oob1_ff, oob1_in;
   logic             small1_ff, small1_in;
   logic             first1_ff, first1_in;
   logic             lt1_ff, lt1_in;
   logic [OUT_W-1:0] prod1_ff, prod1_in;
   logic [OUT_W-1:0] base1_ff, base1_in;
   logic [OUT_W-1:0] minr1_ff, minr1_in;
   logic [gbp_pkg::LAYER_BITS-1:0] lo1_ff, lo1_in;
   logic             oob2_ff, oob2_in;
   logic             small2_ff, small2_in;
   logic [OUT_W-1:0] start2_ff, start2_in;
   logic [OUT_W-1:0] count2_ff, count2_in;
   logic [PROC_BITS:0] idx_ext;
   logic             last;
   logic [OUT_W-1:0] start_base;

   always_comb begin
      idx_ext   = {1'b0, idx};
      last      = (idx_ext + 1'b1) == procs;
      oob1_in   = idx_ext >= procs;
      small1_in = (avg <= AVG_W'(lo)) || (avg <= AVG_W'(hi));
      first1_in = idx == '0;
      lt1_in    = idx_ext < rem;
      prod1_in  = OUT_W'(idx * avg);
      minr1_in  = lt1_in ? OUT_W'(idx_ext) : OUT_W'(rem);
      base1_in  = OUT_W'(avg) - (first1_in ? OUT_W'(lo) : '0) - (last ? OUT_W'(hi) : '0);
      lo1_in    = lo;
   end

   always_comb begin
      start_base = first1_ff ? '0 : (prod1_ff - OUT_W'(lo1_ff));
      start2_in  = start_base + minr1_ff;
      count2_in  = base1_ff + OUT_W'(lt1_ff);
      oob2_in    = oob1_ff;
      small2_in  = small1_ff;
   end

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         oob1_ff   <= oob1_in;
         small1_ff <= small1_in;
         first1_ff <= first1_in;
         lt1_ff    <= lt1_in;
         prod1_ff  <= prod1_in;
         base1_ff  <= base1_in;
         minr1_ff  <= minr1_in;
         lo1_ff    <= lo1_in;
      end
      if (adv.s2) begin
         oob2_ff   <= oob2_in;
         small2_ff <= small2_in;
         start2_ff <= start2_in;
         count2_ff <= count2_in;
      end
   end

   assign start     = start2_ff;
   assign count     = count2_ff;
   assign oob       = oob2_ff;
   assign undersize = small2_ff;

endmodule

>>> rtl/grid_block_partition.sv
// Block partition of a 2-D worker grid: for a worker position it returns the
// first global index and point count along x and z, with the axis totals
// extended by the absorbing layers, the remainder given to the first workers
// and the layer points taken from the end workers. One request transaction
// is taken per cycle and its response passes in turn through the
// multiply/checks, start/count and output registers; response backpressure
// stalls all stages without loss. After reset the block is ready at once.
// After each csr write req_chan.ready stays low while two shift-subtract
// dividers, one quotient bit a cycle, recompute the average block and
// remainder of each axis.
// Depends on gbp_pkg, gbp_if, gbp_div and gbp_axis.
module grid_block_partition #(
   parameter int POINT_BITS = gbp_pkg::POINT_BITS_DEF,
   parameter int PROC_BITS  = gbp_pkg::PROC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   gbp_req_if.sink                             req_chan,
   gbp_rsp_if.source                           rsp_chan,
   input  logic                                csr_we,
   input  logic [gbp_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [((POINT_BITS > PROC_BITS + 1) ? POINT_BITS : PROC_BITS + 1)-1:0] csr_data
);

   localparam int LB    = gbp_pkg::LAYER_BITS;
   localparam int OUT_W = POINT_BITS + 1;
   localparam int PR_W  = PROC_BITS + 1;
   localparam int AVG_W = ((POINT_BITS > LB + 1) ? POINT_BITS : LB + 1) + 1;

   logic [POINT_BITS-1:0] total_x_ff, total_x_in, total_z_ff, total_z_in;
   logic [PR_W-1:0]       procs_x_ff, procs_x_in, procs_z_ff, procs_z_in;
   logic [LB-1:0]         lxl_ff, lxl_in, lxh_ff, lxh_in, lzl_ff, lzl_in, lzh_ff, lzh_in;
   logic                  start_ff;
   logic [AVG_W-1:0]      ext_x, ext_z, avg_x, avg_z;
   logic [PR_W-1:0]       rem_x, rem_z;
   logic                  busy_x, busy_z;

   logic                  v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic                  en1, en2, en3;
   gbp_pkg::advance_type  adv;

   logic [OUT_W-1:0]      start_x, start_z, count_x, count_z;
   logic                  oob_x, oob_z, small_x, small_z;
   gbp_pkg::status_type   status_in, status_ff;
   logic [OUT_W-1:0]      sx_in, sx_ff, sz_in, sz_ff, cx_in, cx_ff, cz_in, cz_ff;

   always_comb begin
      total_x_in = total_x_ff;
      total_z_in = total_z_ff;
      procs_x_in = procs_x_ff;
      procs_z_in = procs_z_ff;
      lxl_in     = lxl_ff;
      lxh_in     = lxh_ff;
      lzl_in     = lzl_ff;
      lzh_in     = lzh_ff;
      if (csr_we) begin
         case (gbp_pkg::csr_index_type'(csr_index))
            gbp_pkg::CSR_TOTAL_X:  total_x_in = csr_data[POINT_BITS-1:0];
            gbp_pkg::CSR_TOTAL_Z:  total_z_in = csr_data[POINT_BITS-1:0];
            gbp_pkg::CSR_PROCS_X:  procs_x_in = csr_data[PR_W-1:0];
            gbp_pkg::CSR_PROCS_Z:  procs_z_in = csr_data[PR_W-1:0];
            gbp_pkg::CSR_LAYER_XL: lxl_in     = csr_data[LB-1:0];
            gbp_pkg::CSR_LAYER_XH: lxh_in     = csr_data[LB-1:0];
            gbp_pkg::CSR_LAYER_ZL: lzl_in     = csr_data[LB-1:0];
            gbp_pkg::CSR_LAYER_ZH: lzh_in     = csr_data[LB-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_x_ff <= POINT_BITS'(1);
         total_z_ff <= POINT_BITS'(1);
         procs_x_ff <= PR_W'(1);
         procs_z_ff <= PR_W'(1);
         lxl_ff     <= '0;
         lxh_ff     <= '0;
         lzl_ff     <= '0;
         lzh_ff     <= '0;
         start_ff   <= 1'b0;
      end else begin
         total_x_ff <= total_x_in;
         total_z_ff <= total_z_in;
         procs_x_ff <= procs_x_in;
         procs_z_ff <= procs_z_in;
         lxl_ff     <= lxl_in;
         lxh_ff     <= lxh_in;
         lzl_ff     <= lzl_in;
         lzh_ff     <= lzh_in;
         start_ff   <= csr_we;
      end
   end

   assign ext_x = AVG_W'(total_x_ff) + AVG_W'(lxl_ff) + AVG_W'(lxh_ff);
   assign ext_z = AVG_W'(total_z_ff) + AVG_W'(lzl_ff) + AVG_W'(lzh_ff);

   gbp_div #(.DVD_W(AVG_W), .DVS_W(PR_W)) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .start     (start_ff),
      .dividend  (ext_x),
      .divisor   (procs_x_ff),
      .quotient  (avg_x),
      .remainder (rem_x),
      .busy      (busy_x)
   );

   gbp_div #(.DVD_W(AVG_W), .DVS_W(PR_W)) u_div_z (
      .clock     (clock),
      .reset     (reset),
      .start     (start_ff),
      .dividend  (ext_z),
      .divisor   (procs_z_ff),
      .quotient  (avg_z),
      .remainder (rem_z),
      .busy      (busy_z)
   );

   // advance a stage when it is empty or its contents move on
   assign en3    = !v3_ff || rsp_chan.ready;
   assign en2    = !v2_ff || en3;
   assign en1    = !v1_ff || en2;
   assign adv.s1 = en1;
   assign adv.s2 = en2;

   assign req_chan.ready = en1 && !csr_we && !start_ff && !busy_x && !busy_z;

   always_comb begin
      v1_in = en1 ? (req_chan.valid && req_chan.ready) : v1_ff;
      v2_in = en2 ? v1_ff : v2_ff;
      v3_in = en3 ? v2_ff : v3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   gbp_axis #(.POINT_BITS(POINT_BITS), .PROC_BITS(PROC_BITS), .AVG_W(AVG_W)) u_axis_x (
      .clock     (clock),
      .adv       (adv),
      .idx       (req_chan.worker_x),
      .procs     (procs_x_ff),
      .avg       (avg_x),
      .rem       (rem_x),
      .lo        (lxl_ff),
      .hi        (lxh_ff),
      .start     (start_x),
      .count     (count_x),
      .oob       (oob_x),
      .undersize (small_x)
   );

   gbp_axis #(.POINT_BITS(POINT_BITS), .PROC_BITS(PROC_BITS), .AVG_W(AVG_W)) u_axis_z (
      .clock     (clock),
      .adv       (adv),
      .idx       (req_chan.worker_z),
      .procs     (procs_z_ff),
      .avg       (avg_z),
      .rem       (rem_z),
      .lo        (lzl_ff),
      .hi        (lzh_ff),
      .start     (start_z),
      .count     (count_z),
      .oob       (oob_z),
      .undersize (small_z)
   );

   always_comb begin
      if (oob_x || oob_z) begin
         status_in = gbp_pkg::STATUS_RANGE;
      end else if (small_x) begin
         status_in = gbp_pkg::STATUS_X_SMALL;
      end else if (small_z) begin
         status_in = gbp_pkg::STATUS_Z_SMALL;
      end else begin
         status_in = gbp_pkg::STATUS_OK;
      end
      if (status_in == gbp_pkg::STATUS_OK) begin
         sx_in = start_x;
         sz_in = start_z;
         cx_in = count_x;
         cz_in = count_z;
      end else begin
         sx_in = '0;
         sz_in = '0;
         cx_in = '0;
         cz_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         status_ff <= status_in;
         sx_ff     <= sx_in;
         sz_ff     <= sz_in;
         cx_ff     <= cx_in;
         cz_ff     <= cz_in;
      end
   end

   assign rsp_chan.valid   = v3_ff;
   assign rsp_chan.start_x = sx_ff;
   assign rsp_chan.start_z = sz_ff;
   assign rsp_chan.count_x = cx_ff;
   assign rsp_chan.count_z = cz_ff;
   assign rsp_chan.status  = status_ff;

endmodule
